// ===== rtl/cfsp_pkg.sv =====
`timescale 1ns / 1ps

package cfsp_pkg;

    // Depth of the result queue; it must hold the two results of one byte.
    localparam int OUT_DEPTH = 4;

    // Stream and register port widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;
    localparam int KIND_W      = 4;
    localparam int CODE_W      = 4;
    localparam int VALUE_W     = 64;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    // Format constants.
    localparam logic [31:0] TRAILER_BYTES   = 32'd4;
    localparam logic [31:0] RANGE_HDR_BYTES = 32'd12;
    localparam logic [31:0] HDR_LEN_V1      = 32'd28;
    localparam logic [31:0] HDR_LEN_V2      = 32'd44;
    localparam logic [7:0]  MAX_VERSION_RST = 8'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VERSION = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] K_VERSION   = 4'd0;
    localparam logic [KIND_W-1:0] K_COUNT     = 4'd1;
    localparam logic [KIND_W-1:0] K_WIDTH     = 4'd2;
    localparam logic [KIND_W-1:0] K_HEIGHT    = 4'd3;
    localparam logic [KIND_W-1:0] K_HEAP_BASE = 4'd4;
    localparam logic [KIND_W-1:0] K_HEAP_SIZE = 4'd5;
    localparam logic [KIND_W-1:0] K_ROM_BASE  = 4'd6;
    localparam logic [KIND_W-1:0] K_ROM_SIZE  = 4'd7;
    localparam logic [KIND_W-1:0] K_ROOT      = 4'd8;
    localparam logic [KIND_W-1:0] K_RANGE_ADR = 4'd9;
    localparam logic [KIND_W-1:0] K_RANGE_LEN = 4'd10;
    localparam logic [KIND_W-1:0] K_DATA      = 4'd11;
    localparam logic [KIND_W-1:0] K_ACCEPTED  = 4'd12;
    localparam logic [KIND_W-1:0] K_ERROR     = 4'd13;

    // Error codes.
    localparam logic [CODE_W-1:0] E_NONE         = 4'd0;
    localparam logic [CODE_W-1:0] E_MAGIC        = 4'd1;
    localparam logic [CODE_W-1:0] E_VERSION      = 4'd2;
    localparam logic [CODE_W-1:0] E_HEADER       = 4'd3;
    localparam logic [CODE_W-1:0] E_COUNT        = 4'd4;
    localparam logic [CODE_W-1:0] E_RANGE_HDR    = 4'd6;
    localparam logic [CODE_W-1:0] E_RANGE_LEN    = 4'd7;
    localparam logic [CODE_W-1:0] E_TRAILER_MISS = 4'd8;
    localparam logic [CODE_W-1:0] E_TRAILER_BAD  = 4'd9;

    // Parser phases.
    typedef enum logic [13:0] {
        PH_SIG     = 14'h0001,
        PH_VERSION = 14'h0002,
        PH_COUNT   = 14'h0004,
        PH_WIDTH   = 14'h0008,
        PH_HEIGHT  = 14'h0010,
        PH_HBASE   = 14'h0020,
        PH_HSIZE   = 14'h0040,
        PH_RBASE   = 14'h0080,
        PH_RSIZE   = 14'h0100,
        PH_ROOT    = 14'h0200,
        PH_RADDR   = 14'h0400,
        PH_RLEN    = 14'h0800,
        PH_BODY    = 14'h1000,
        PH_TRAILER = 14'h2000
    } phase_t;

    // One result item.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [CODE_W-1:0]  code;
        logic               last;
    } result_t;

    // Results produced by one byte, first one in r0.
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } res_pair_t;

    // Signature bytes in file order.
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h50;
            2'd1:    b = 8'h44;
            2'd2:    b = 8'h44;
            default: b = 8'h4C;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/capture_file_stream_parser.sv =====
`timescale 1ns / 1ps

// Streaming parser for one capture file. Program file_length (index 0) and, if
// needed, max_version (index 1) while the block is idle, then stream the file one
// byte per input beat. Each byte is registered and parsed from that register, so
// the block takes one byte per clock while the queue has room; a byte that yields
// a decoded field and an error in the same step puts two beats into the result
// queue, and the queue's single output beat per cycle is what sets the sustained
// rate when that happens. Results carry the kind on tuser, the value and the
// error code on tdata, and tlast marks the final result of a byte. After an error
// or an accepted trailer the remaining bytes are absorbed, and the parser rearms
// on the file's last byte. No clearing pass is needed after reset.
module capture_file_stream_parser
    import cfsp_pkg::*;
#(
    parameter int OUT_Q_DEPTH = OUT_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // data_byte[7:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,    // value[63:0], error_code[67:64], zero pad
    output logic [KIND_W-1:0]      m_tuser,    // kind[3:0]
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    res_pair_t push;
    logic      room;

    // Byte parser with its input register and configuration.
    cfsp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .room      (room),
        .push      (push)
    );

    // Result queue feeding the output stream.
    cfsp_outq #(
        .DEPTH (OUT_Q_DEPTH)
    ) u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/cfsp_outq.sv =====
`timescale 1ns / 1ps

module cfsp_outq
    import cfsp_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  res_pair_t              push,
    output logic                   room,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // value[63:0], error_code[67:64], zero pad
    output logic [KIND_W-1:0]      m_tuser,   // kind[3:0]
    output logic                   m_tlast
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;
    result_t            head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Room for both results of the next byte.
    assign room     = (count_reg <= CNT_W'(DEPTH - 2));
    assign pop      = m_tvalid && m_tready;
    assign head     = mem_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {{(OUT_TDATA_W - VALUE_W - CODE_W){1'b0}}, head.code, head.value};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
        wr_ptr_next  = wr_ptr_reg;
        if (push.v1)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_plus1);
        end
        else if (push.v0)
        begin
            wr_ptr_next = wr_ptr_plus1;
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem_reg[wr_ptr_plus1] <= push.r1;
        end
    end

endmodule

// ===== rtl/cfsp_core.sv =====
`timescale 1ns / 1ps

module cfsp_core
    import cfsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,    // data_byte[7:0]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  room,
    output res_pair_t             push
);

    // Input register.
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         fire;

    // Configuration.
    logic [31:0]  file_length_reg;
    logic [7:0]   max_version_reg;

    // Parser state.
    phase_t       phase_reg,     phase_next;
    logic [31:0]  position_reg,  position_next;
    logic [2:0]   fbi_reg,       fbi_next;
    logic [63:0]  asm_reg,       asm_next;
    logic [7:0]   fver_reg,      fver_next;
    logic [31:0]  roots_reg,     roots_next;
    logic [31:0]  body_reg,      body_next;
    logic [31:0]  ranges_reg,    ranges_next;
    logic         absorb_reg,    absorb_next;

    // Per-byte working values.
    logic [31:0]       rem;
    logic [31:0]       after;
    logic [31:0]       avail;
    logic [63:0]       asm_ins;
    logic              wide_field;
    logic              field_done;
    logic [1:0]        sig_idx;
    logic [31:0]       roots_dec;
    logic [31:0]       body_dec;
    phase_t            dec_phase;
    logic              dec_fail;
    phase_t            hdr_phase;
    logic              hdr_fail;
    logic [CODE_W-1:0] hdr_code;
    logic              emit_v;
    logic [KIND_W-1:0] emit_kind;
    logic [63:0]       emit_val;
    logic              fail_v;
    logic [CODE_W-1:0] fail_code;
    result_t           emit_res;
    result_t           fail_res;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    // Input beat register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
            max_version_reg <= MAX_VERSION_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILE_LENGTH: file_length_reg <= cfg_wdata;
                CFG_MAX_VERSION: max_version_reg <= cfg_wdata[7:0];
                default:         ;
            endcase
        end
    end

    // Bytes left, field assembly and the shared end-of-item decisions.
    always_comb
    begin
        rem     = (position_reg < file_length_reg) ? file_length_reg - position_reg : 32'd1;
        after   = rem - 32'd1;
        avail   = (after > TRAILER_BYTES) ? after - TRAILER_BYTES : 32'd0;
        asm_ins = asm_reg;
        asm_ins[{fbi_reg, 3'b000} +: 8] = in_byte_reg;
        sig_idx = fbi_reg[1:0];
        wide_field = (phase_reg == PH_HBASE) || (phase_reg == PH_HSIZE) ||
                     (phase_reg == PH_RBASE) || (phase_reg == PH_RSIZE) ||
                     (phase_reg == PH_ROOT)  || (phase_reg == PH_RADDR);
        field_done = (fbi_reg == (wide_field ? 3'd7 : 3'd3));
        roots_dec  = roots_reg - 32'd1;
        body_dec   = body_reg - 32'd1;

        // Next item after a range or the root table.
        dec_fail  = 1'b0;
        dec_phase = PH_TRAILER;
        if (after > TRAILER_BYTES)
        begin
            dec_phase = PH_RADDR;
        end
        else if (after != TRAILER_BYTES)
        begin
            dec_fail = 1'b1;
        end

        // End of header: the root table must fit in the bytes left.
        hdr_fail  = 1'b0;
        hdr_code  = E_NONE;
        hdr_phase = PH_ROOT;
        if ({roots_reg, 3'b000} > {3'b000, after})
        begin
            hdr_fail = 1'b1;
            hdr_code = E_COUNT;
        end
        else if (roots_reg == 32'd0)
        begin
            hdr_phase = dec_phase;
            hdr_fail  = dec_fail;
            hdr_code  = E_TRAILER_MISS;
        end
    end

    // Parser step for one accepted byte.
    always_comb
    begin
        phase_next    = phase_reg;
        position_next = position_reg;
        fbi_next      = fbi_reg;
        asm_next      = asm_reg;
        fver_next     = fver_reg;
        roots_next    = roots_reg;
        body_next     = body_reg;
        ranges_next   = ranges_reg;
        absorb_next   = absorb_reg;
        emit_v        = 1'b0;
        emit_kind     = K_VERSION;
        emit_val      = '0;
        fail_v        = 1'b0;
        fail_code     = E_NONE;

        if (fire && !absorb_reg)
        begin
            if (phase_reg == PH_SIG)
            begin
                if ((sig_idx == 2'd0 && rem < TRAILER_BYTES) ||
                    in_byte_reg != sig_byte(sig_idx))
                begin
                    fail_v    = 1'b1;
                    fail_code = E_MAGIC;
                end
                else if (sig_idx == 2'd3)
                begin
                    fbi_next   = 3'd0;
                    phase_next = PH_VERSION;
                end
                else
                begin
                    fbi_next = {1'b0, sig_idx + 2'd1};
                end
            end
            else if (phase_reg == PH_BODY)
            begin
                emit_v    = 1'b1;
                emit_kind = K_DATA;
                emit_val  = {56'd0, in_byte_reg};
                body_next = body_dec;
                if (body_dec == 32'd0)
                begin
                    ranges_next = ranges_reg + 32'd1;
                    phase_next  = dec_phase;
                    fail_v      = dec_fail;
                    fail_code   = E_TRAILER_MISS;
                end
            end
            else if (fbi_reg == 3'd0 && phase_reg == PH_VERSION && rem < TRAILER_BYTES)
            begin
                fail_v    = 1'b1;
                fail_code = E_VERSION;
            end
            else if (fbi_reg == 3'd0 && phase_reg == PH_RADDR && rem < RANGE_HDR_BYTES)
            begin
                fail_v    = 1'b1;
                fail_code = E_RANGE_HDR;
            end
            else if (!field_done)
            begin
                asm_next = asm_ins;
                fbi_next = fbi_reg + 3'd1;
            end
            else
            begin
                asm_next = '0;
                fbi_next = 3'd0;
                emit_val = asm_ins;
                unique case (phase_reg)
                    PH_VERSION:
                    begin
                        if (asm_ins[31:0] == 32'd0 ||
                            asm_ins[31:0] > {24'd0, max_version_reg})
                        begin
                            fail_v    = 1'b1;
                            fail_code = E_VERSION;
                        end
                        else
                        begin
                            fver_next = asm_ins[7:0];
                            emit_v    = 1'b1;
                            emit_kind = K_VERSION;
                            if (after < ((asm_ins[7:0] >= 8'd2) ? HDR_LEN_V2 : HDR_LEN_V1))
                            begin
                                fail_v    = 1'b1;
                                fail_code = E_HEADER;
                            end
                            else
                            begin
                                phase_next = PH_COUNT;
                            end
                        end
                    end
                    PH_COUNT:
                    begin
                        roots_next = asm_ins[31:0];
                        emit_v     = 1'b1;
                        emit_kind  = K_COUNT;
                        phase_next = PH_WIDTH;
                    end
                    PH_WIDTH:
                    begin
                        emit_v     = 1'b1;
                        emit_kind  = K_WIDTH;
                        phase_next = PH_HEIGHT;
                    end
                    PH_HEIGHT:
                    begin
                        emit_v     = 1'b1;
                        emit_kind  = K_HEIGHT;
                        phase_next = PH_HBASE;
                    end
                    PH_HBASE:
                    begin
                        emit_v     = 1'b1;
                        emit_kind  = K_HEAP_BASE;
                        phase_next = PH_HSIZE;
                    end
                    PH_HSIZE:
                    begin
                        emit_v    = 1'b1;
                        emit_kind = K_HEAP_SIZE;
                        if (fver_reg >= 8'd2)
                        begin
                            phase_next = PH_RBASE;
                        end
                        else
                        begin
                            phase_next = hdr_phase;
                            fail_v     = hdr_fail;
                            fail_code  = hdr_code;
                        end
                    end
                    PH_RBASE:
                    begin
                        emit_v     = 1'b1;
                        emit_kind  = K_ROM_BASE;
                        phase_next = PH_RSIZE;
                    end
                    PH_RSIZE:
                    begin
                        emit_v     = 1'b1;
                        emit_kind  = K_ROM_SIZE;
                        phase_next = hdr_phase;
                        fail_v     = hdr_fail;
                        fail_code  = hdr_code;
                    end
                    PH_ROOT:
                    begin
                        emit_v     = 1'b1;
                        emit_kind  = K_ROOT;
                        roots_next = roots_dec;
                        if (roots_dec == 32'd0)
                        begin
                            phase_next = dec_phase;
                            fail_v     = dec_fail;
                            fail_code  = E_TRAILER_MISS;
                        end
                    end
                    PH_RADDR:
                    begin
                        emit_v     = 1'b1;
                        emit_kind  = K_RANGE_ADR;
                        phase_next = PH_RLEN;
                    end
                    PH_RLEN:
                    begin
                        emit_v    = 1'b1;
                        emit_kind = K_RANGE_LEN;
                        if (asm_ins[31:0] > avail)
                        begin
                            fail_v    = 1'b1;
                            fail_code = E_RANGE_LEN;
                        end
                        else if (asm_ins[31:0] == 32'd0)
                        begin
                            ranges_next = ranges_reg + 32'd1;
                            phase_next  = dec_phase;
                            fail_v      = dec_fail;
                            fail_code   = E_TRAILER_MISS;
                        end
                        else
                        begin
                            body_next  = asm_ins[31:0];
                            phase_next = PH_BODY;
                        end
                    end
                    default:
                    begin
                        // Trailer: range count check, then wait for the end of file.
                        absorb_next = 1'b1;
                        if (asm_ins[31:0] == ranges_reg)
                        begin
                            emit_v    = 1'b1;
                            emit_kind = K_ACCEPTED;
                            emit_val  = {32'd0, ranges_reg};
                        end
                        else
                        begin
                            fail_v    = 1'b1;
                            fail_code = E_TRAILER_BAD;
                        end
                    end
                endcase
            end

            if (fail_v)
            begin
                absorb_next = 1'b1;
            end
        end

        if (fire)
        begin
            position_next = position_reg + 32'd1;
            // The final byte of a file rearms the parser.
            if (rem == 32'd1)
            begin
                phase_next    = PH_SIG;
                position_next = '0;
                fbi_next      = '0;
                asm_next      = '0;
                fver_next     = '0;
                roots_next    = '0;
                body_next     = '0;
                ranges_next   = '0;
                absorb_next   = 1'b0;
            end
        end
    end

    // Result assembly: a field comes first, an error after it.
    always_comb
    begin
        emit_res.kind  = emit_kind;
        emit_res.value = emit_val;
        emit_res.code  = E_NONE;
        emit_res.last  = !fail_v;
        fail_res.kind  = K_ERROR;
        fail_res.value = '0;
        fail_res.code  = fail_code;
        fail_res.last  = 1'b1;

        push.v0 = emit_v || fail_v;
        push.v1 = emit_v && fail_v;
        push.r0 = emit_v ? emit_res : fail_res;
        push.r1 = fail_res;
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SIG;
            position_reg <= '0;
            fbi_reg      <= '0;
            asm_reg      <= '0;
            fver_reg     <= '0;
            roots_reg    <= '0;
            body_reg     <= '0;
            ranges_reg   <= '0;
            absorb_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            fbi_reg      <= fbi_next;
            asm_reg      <= asm_next;
            fver_reg     <= fver_next;
            roots_reg    <= roots_next;
            body_reg     <= body_next;
            ranges_reg   <= ranges_next;
            absorb_reg   <= absorb_next;
        end
    end

endmodule

// ===== sim/tb_capture_file_stream_parser.sv =====
`timescale 1ns / 1ps

module tb_capture_file_stream_parser;
    import cfsp_pkg::*;

    // Settling time after the last expected result, and the run's hard limit.
    localparam int          SETTLE_CYCLES  = 8;
    localparam time         RUN_LIMIT_NS   = 15_000_000;
    localparam int          RANDOM_BYTES   = 400;
    localparam int          WORD_BYTES     = 4;
    localparam int          DWORD_BYTES    = 8;
    // Signature bytes in file order, first byte in the low bits.
    localparam logic [31:0] FILE_SIGNATURE = 32'h4C44_4450;

    // Field fill styles used when a file image is built.
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZEROS  = 1;
    localparam int FILL_ONES   = 2;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;     // value[63:0], error_code[67:64], zero pad
    logic [KIND_W-1:0]      m_tuser;     // kind[3:0]
    logic                   m_tlast;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    capture_file_stream_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Expected result beats, oldest first, and the beats of the byte being decoded.
    result_t     pending_results[$];
    result_t     byte_results[$];
    logic [7:0]  file_image[$];
    int          mismatch_count = 0;
    int          bytes_sent     = 0;
    bit          src_quiet      = 1'b0;
    bit          sink_quiet     = 1'b0;
    int          fill_style     = FILL_RANDOM;

    // Parser state as the decoder sees it.
    phase_t      cur_phase;
    logic [31:0] file_pos;
    int          byte_in_field;
    logic [63:0] field_word;
    logic [31:0] fmt_version;
    logic [31:0] roots_left;
    logic [31:0] body_left;
    logic [31:0] ranges_done;
    bit          absorbing;
    logic [31:0] length_reg;
    logic [7:0]  max_version_reg;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on the whole run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Mostly short gaps, now and then a long one; none while quiet.
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    // ------------------------------------------------------------------
    // Decoder of the capture file format, one byte at a time.
    // ------------------------------------------------------------------

    function void rearm_parser();
        cur_phase     = PH_SIG;
        file_pos      = '0;
        byte_in_field = 0;
        field_word    = '0;
        fmt_version   = '0;
        roots_left    = '0;
        body_left     = '0;
        ranges_done   = '0;
        absorbing     = 1'b0;
    endfunction

    function void note_result(input logic [KIND_W-1:0] kind, input logic [63:0] value,
                              input logic [CODE_W-1:0] code);
        result_t r;
        r.kind  = kind;
        r.value = value;
        r.code  = code;
        r.last  = 1'b0;
        if (byte_results.size() < 2)
            byte_results.insert(byte_results.size(), r);
    endfunction

    function void note_failure(input logic [CODE_W-1:0] code);
        note_result(K_ERROR, 64'd0, code);
        absorbing = 1'b1;
    endfunction

    // At a range boundary: another range, the trailer, or no room for the trailer.
    function void route_after_item(input logic [31:0] after);
        if (after > TRAILER_BYTES)
            cur_phase = PH_RADDR;
        else if (after == TRAILER_BYTES)
            cur_phase = PH_TRAILER;
        else
            note_failure(E_TRAILER_MISS);
    endfunction

    function void finish_header(input logic [31:0] after);
        if ({32'd0, roots_left} * 64'd8 > {32'd0, after})
            note_failure(E_COUNT);
        else if (roots_left == 0)
            route_after_item(after);
        else
            cur_phase = PH_ROOT;
    endfunction

    // A whole field has been assembled; report it and move on.
    function void take_field(input logic [63:0] v, input logic [31:0] after);
        logic [31:0] room;
        case (cur_phase)
            PH_VERSION:
            begin
                if (v == 0 || v > {56'd0, max_version_reg})
                begin
                    note_failure(E_VERSION);
                end
                else
                begin
                    fmt_version = v[31:0];
                    note_result(K_VERSION, v, E_NONE);
                    if (after < ((fmt_version >= 2) ? HDR_LEN_V2 : HDR_LEN_V1))
                        note_failure(E_HEADER);
                    else
                        cur_phase = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                roots_left = v[31:0];
                note_result(K_COUNT, v, E_NONE);
                cur_phase = PH_WIDTH;
            end
            PH_WIDTH:
            begin
                note_result(K_WIDTH, v, E_NONE);
                cur_phase = PH_HEIGHT;
            end
            PH_HEIGHT:
            begin
                note_result(K_HEIGHT, v, E_NONE);
                cur_phase = PH_HBASE;
            end
            PH_HBASE:
            begin
                note_result(K_HEAP_BASE, v, E_NONE);
                cur_phase = PH_HSIZE;
            end
            PH_HSIZE:
            begin
                note_result(K_HEAP_SIZE, v, E_NONE);
                if (fmt_version >= 2)
                    cur_phase = PH_RBASE;
                else
                    finish_header(after);
            end
            PH_RBASE:
            begin
                note_result(K_ROM_BASE, v, E_NONE);
                cur_phase = PH_RSIZE;
            end
            PH_RSIZE:
            begin
                note_result(K_ROM_SIZE, v, E_NONE);
                finish_header(after);
            end
            PH_ROOT:
            begin
                note_result(K_ROOT, v, E_NONE);
                roots_left = roots_left - 1;
                if (roots_left == 0)
                    route_after_item(after);
            end
            PH_RADDR:
            begin
                note_result(K_RANGE_ADR, v, E_NONE);
                cur_phase = PH_RLEN;
            end
            PH_RLEN:
            begin
                room = (after > TRAILER_BYTES) ? after - TRAILER_BYTES : 32'd0;
                note_result(K_RANGE_LEN, v, E_NONE);
                if (v > {32'd0, room})
                begin
                    note_failure(E_RANGE_LEN);
                end
                else
                begin
                    body_left = v[31:0];
                    if (body_left == 0)
                    begin
                        ranges_done = ranges_done + 1;
                        route_after_item(after);
                    end
                    else
                    begin
                        cur_phase = PH_BODY;
                    end
                end
            end
            default:
            begin
                // Trailer: the stored count must match the ranges seen.
                if (v == {32'd0, ranges_done})
                    note_result(K_ACCEPTED, {32'd0, ranges_done}, E_NONE);
                else
                    note_failure(E_TRAILER_BAD);
                absorbing = 1'b1;
            end
        endcase
    endfunction

    function void parse_byte(input logic [7:0] b, input logic [31:0] rem);
        logic [31:0] after;
        int          field_len;
        logic [63:0] v;
        after = rem - 1;
        if (cur_phase == PH_SIG)
        begin
            if ((byte_in_field == 0 && rem < WORD_BYTES)
                || b != FILE_SIGNATURE[8*byte_in_field +: 8])
            begin
                note_failure(E_MAGIC);
                return;
            end
            byte_in_field = byte_in_field + 1;
            if (byte_in_field == WORD_BYTES)
            begin
                byte_in_field = 0;
                cur_phase = PH_VERSION;
            end
            return;
        end
        if (cur_phase == PH_BODY)
        begin
            note_result(K_DATA, {56'd0, b}, E_NONE);
            body_left = body_left - 1;
            if (body_left == 0)
            begin
                ranges_done = ranges_done + 1;
                route_after_item(after);
            end
            return;
        end
        field_len = (cur_phase == PH_HBASE || cur_phase == PH_HSIZE || cur_phase == PH_RBASE
                     || cur_phase == PH_RSIZE || cur_phase == PH_ROOT
                     || cur_phase == PH_RADDR) ? DWORD_BYTES : WORD_BYTES;
        // Truncation checks on the first byte of a version field or a range header.
        if (byte_in_field == 0)
        begin
            if (cur_phase == PH_VERSION && rem < WORD_BYTES)
            begin
                note_failure(E_VERSION);
                return;
            end
            if (cur_phase == PH_RADDR && rem < RANGE_HDR_BYTES)
            begin
                note_failure(E_RANGE_HDR);
                return;
            end
        end
        field_word = field_word | ({56'd0, b} << (8 * byte_in_field));
        byte_in_field = byte_in_field + 1;
        if (byte_in_field == field_len)
        begin
            v = field_word;
            field_word = '0;
            byte_in_field = 0;
            take_field(v, after);
        end
    endfunction

    // Decode one accepted byte and queue the result beats it causes.
    function void decode_file_byte(input logic [7:0] b);
        logic [31:0] rem;
        result_t     r;
        rem = (file_pos < length_reg) ? length_reg - file_pos : 32'd1;
        byte_results.delete();
        if (!absorbing)
            parse_byte(b, rem);
        file_pos = file_pos + 1;
        if (rem == 1)
            rearm_parser();
        foreach (byte_results[i])
        begin
            r = byte_results[i];
            r.last = (i == byte_results.size() - 1);
            pending_results.insert(pending_results.size(), r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the beat checker.
    // ------------------------------------------------------------------

    initial
    begin : sink_pacing
        int run_len;
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
            repeat (run_len) @(posedge clk);
            stall = pick_gap(sink_quiet);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with none expected: kind %0d value %h code %0d",
                       m_tuser, m_tdata[63:0], m_tdata[67:64]);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[63:0] !== want.value)
                begin
                    $error("value: expected %h, got %h", want.value, m_tdata[63:0]);
                    mismatch_count++;
                end
                if (m_tdata[67:64] !== want.code)
                begin
                    $error("error_code: expected %0d, got %0d", want.code, m_tdata[67:64]);
                    mismatch_count++;
                end
                if (m_tdata[71:68] !== 4'd0)
                begin
                    $error("pad: expected 0, got %h", m_tdata[71:68]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    task send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(src_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        decode_file_byte(b);
        bytes_sent++;
    endtask

    // Let every expected beat drain, then allow for bytes still in flight.
    task wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_FILE_LENGTH)
            length_reg = data;
        else
            max_version_reg = data[7:0];
    endtask

    task set_max_version(input logic [7:0] v);
        wait_idle();
        write_reg(CFG_MAX_VERSION, {24'd0, v});
    endtask

    function logic [63:0] pick_field();
        if (fill_style == FILL_ZEROS)
            return 64'd0;
        if (fill_style == FILL_ONES)
            return {64{1'b1}};
        return {$urandom, $urandom};
    endfunction

    function void put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_image.insert(file_image.size(), v[8*i +: 8]);
    endfunction

    // Build a well-formed file image with the given layout.
    function void build_file(input logic [31:0] ver, input int nroots, input int nranges,
                             input int max_len);
        int len;
        file_image.delete();
        put_le({32'd0, FILE_SIGNATURE}, WORD_BYTES);
        put_le({32'd0, ver}, WORD_BYTES);
        put_le(64'(nroots), WORD_BYTES);
        put_le(pick_field(), WORD_BYTES);
        put_le(pick_field(), WORD_BYTES);
        put_le(pick_field(), DWORD_BYTES);
        put_le(pick_field(), DWORD_BYTES);
        if (ver >= 2)
        begin
            put_le(pick_field(), DWORD_BYTES);
            put_le(pick_field(), DWORD_BYTES);
        end
        repeat (nroots)
            put_le(pick_field(), DWORD_BYTES);
        repeat (nranges)
        begin
            len = $urandom_range(0, max_len);
            put_le(pick_field(), DWORD_BYTES);
            put_le(64'(len), WORD_BYTES);
            repeat (len)
                file_image.insert(file_image.size(), 8'(pick_field()));
        end
        put_le(64'(nranges), WORD_BYTES);
    endfunction

    // Stream part of the image; positions past its end get random bytes.
    task stream_bytes(input int from_idx, input int count);
        logic [7:0] b;
        for (int k = from_idx; k < from_idx + count; k++)
        begin
            b = 8'($urandom);
            if (k < file_image.size())
                b = file_image[k];
            send_byte(b);
        end
    endtask

    task run_file(input logic [31:0] flen, input int count);
        wait_idle();
        write_reg(CFG_FILE_LENGTH, flen);
        stream_bytes(0, count);
    endtask

    task run_image();
        run_file(file_image.size(), file_image.size());
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Length register still zero after reset: every byte is a file of its own.
    task test_unset_length();
        send_byte(8'h50);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task test_clean_files();
        fill_style = FILL_ZEROS;
        build_file(1, 0, 0, 0);
        run_image();
        fill_style = FILL_ONES;
        build_file(2, 2, 2, 3);
        run_image();
        fill_style = FILL_RANDOM;
        build_file(2, 3, 3, 5);
        run_image();
    endtask

    task test_signature_errors();
        for (int k = 0; k < WORD_BYTES; k++)
        begin
            build_file(1, 0, 0, 0);
            file_image[k] = file_image[k] ^ (8'h01 << k);
            run_image();
        end
        // Too short to hold the signature at all.
        build_file(1, 0, 0, 0);
        run_file(3, 3);
    endtask

    task test_header_errors();
        build_file(0, 0, 0, 0);
        run_image();
        build_file(3, 0, 0, 0);
        run_image();
        build_file(32'hFFFF_FFFF, 0, 0, 0);
        run_image();
        // Version field cut short, then headers one byte too short.
        build_file(1, 0, 0, 0);
        run_file(7, 7);
        run_file(35, 35);
        build_file(2, 0, 0, 0);
        run_file(51, 51);
        // Root count far beyond the space left.
        build_file(1, 0, 0, 0);
        for (int k = 8; k < 12; k++)
            file_image[k] = 8'hFF;
        run_image();
    endtask

    task test_range_errors();
        int sz;
        // Room after the header, but not for a whole range header.
        build_file(1, 0, 0, 0);
        run_file(45, 45);
        // Range length beyond the space left.
        build_file(1, 0, 1, 0);
        sz = file_image.size();
        for (int k = sz - 8; k < sz - 4; k++)
            file_image[k] = 8'hFF;
        run_image();
        // Trailer cut short after a range and after the header.
        build_file(1, 0, 1, 0);
        sz = file_image.size();
        run_file(sz - 1, sz - 1);
        run_file(sz - 3, sz - 3);
        build_file(1, 0, 0, 0);
        run_file(38, 38);
        // Trailer count off by one.
        build_file(2, 1, 2, 3);
        sz = file_image.size();
        file_image[sz - 4] = file_image[sz - 4] ^ 8'h01;
        run_image();
    endtask

    task test_version_limit();
        set_max_version(8'd1);
        build_file(1, 1, 1, 2);
        run_image();
        build_file(2, 1, 1, 2);
        run_image();
        set_max_version(8'd255);
        build_file(255, 1, 1, 2);
        run_image();
        build_file(256, 1, 1, 2);
        run_image();
        set_max_version(MAX_VERSION_RST);
    endtask

    // The length register is rewritten while a file is half way through.
    task test_length_change();
        build_file(2, 1, 1, 4);
        run_file(32'hFFFF_FFFF, 20);
        wait_idle();
        write_reg(CFG_FILE_LENGTH, 32'd21);
        stream_bytes(20, 1);
        run_file(32'hFFFF_FFFF, 10);
        wait_idle();
        write_reg(CFG_FILE_LENGTH, 32'd4);
        stream_bytes(10, 1);
        run_file(32'hFFFF_FFFF, 12);
        wait_idle();
        write_reg(CFG_FILE_LENGTH, file_image.size());
        stream_bytes(12, file_image.size() - 12);
    endtask

    // The same file three times with no gaps and no back-pressure.
    task test_back_to_back();
        build_file(1, 1, 2, 4);
        src_quiet  = 1'b1;
        sink_quiet = 1'b1;
        run_image();
        stream_bytes(0, file_image.size());
        stream_bytes(0, file_image.size());
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
    endtask

    task test_random_files();
        int          stop_at;
        int          r;
        int          sz;
        int          k;
        logic [31:0] ver;
        logic [31:0] flen;
        int          count;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                r = $urandom_range(0, 3);
                set_max_version(r == 0 ? 8'd1 : r == 1 ? 8'd2 : r == 2 ? 8'd255
                                : 8'($urandom_range(1, 255)));
            end
            fill_style = ($urandom_range(0, 9) == 0) ? $urandom_range(FILL_ZEROS, FILL_ONES)
                                                     : FILL_RANDOM;
            r = $urandom_range(0, 99);
            if (max_version_reg == 1 || r < 40)
                ver = 1;
            else if (r < 80)
                ver = 2;
            else
                ver = $urandom_range(2, max_version_reg);
            build_file(ver, $urandom_range(0, 2), $urandom_range(0, 3),
                       ($urandom_range(0, 7) == 0) ? 24 : 6);
            sz    = file_image.size();
            flen  = sz;
            count = sz;
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                // Well-formed file.
            end
            else if (r < 65)
            begin
                k = $urandom_range(0, (sz < 64 ? sz : 64) - 1);
                file_image[k] = 8'($urandom);
            end
            else if (r < 75)
            begin
                flen  = $urandom_range(0, sz - 1);
                count = flen;
            end
            else if (r < 82)
            begin
                flen  = sz + $urandom_range(1, 12);
                count = flen;
            end
            else if (r < 88)
            begin
                file_image[sz - 4] = file_image[sz - 4] ^ (8'h01 << $urandom_range(0, 7));
            end
            else if (r < 93)
            begin
                put_le(0, 0);
                for (int j = 4; j < 8; j++)
                    file_image[j] = 8'($urandom);
            end
            else
            begin
                for (int j = 8; j < 12; j++)
                    file_image[j] = 8'($urandom);
            end
            // Now and then only noise, down to files of no length at all.
            if ($urandom_range(0, 9) == 0)
            begin
                file_image.delete();
                flen  = $urandom_range(0, 6);
                count = (flen == 0) ? $urandom_range(1, 3) : flen;
            end
            if ($urandom_range(0, 6) == 0)
            begin
                src_quiet  = 1'b1;
                sink_quiet = 1'b1;
            end
            run_file(flen, count);
            if (count == flen && $urandom_range(0, 6) == 0)
                stream_bytes(0, count);
            src_quiet  = 1'b0;
            sink_quiet = 1'b0;
        end
    endtask

    initial
    begin
        length_reg      = '0;
        max_version_reg = MAX_VERSION_RST;
        rearm_parser();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unset_length();
        test_clean_files();
        test_signature_errors();
        test_header_errors();
        test_range_errors();
        test_version_limit();
        test_length_change();
        test_back_to_back();
        test_random_files();
        wait_idle();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
